@@ design/kscd_pkg.sv @@
// ----------------------------------------------------------------------------
// kscd_pkg - shared types and constants
// Key codes, display mode states, clock fields, configuration and segment codes.
// ----------------------------------------------------------------------------
package kscd_pkg;

	// key combinations on keys[2:0]: bit0 READ, bit1 SET, bit2 CHG
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_READ = 3'd1;
	localparam logic [2:0] KEY_SET  = 3'd2;
	localparam logic [2:0] KEY_RC   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_TPS = 2'd0;
	localparam logic [1:0] CFG_LPT = 2'd1;
	localparam logic [1:0] CFG_FEB = 2'd2;

	localparam logic [15:0] TPS_RESET = 16'd512;
	localparam logic [9:0]  LPT_RESET = 10'd512;
	localparam logic [4:0]  FEB_RESET = 5'd29;

	// active-low segment codes
	localparam logic [7:0] SEG_BLANK = 8'hff;
	localparam logic [7:0] SEG_AM    = 8'hc0;
	localparam logic [7:0] SEG_PM    = 8'hc4;

	// display mode codes as seen on the output
	localparam logic [2:0] DMODE_OFF  = 3'd0;
	localparam logic [2:0] DMODE_HHMM = 3'd1;
	localparam logic [2:0] DMODE_SS   = 3'd2;
	localparam logic [2:0] DMODE_HH   = 3'd3;
	localparam logic [2:0] DMODE_MIN  = 3'd4;
	localparam logic [2:0] DMODE_MON  = 3'd5;
	localparam logic [2:0] DMODE_DOM  = 3'd6;

	typedef enum logic [6:0] {
		MODE_OFF  = 7'b0000001,
		MODE_HHMM = 7'b0000010,
		MODE_SS   = 7'b0000100,
		MODE_HH   = 7'b0001000,
		MODE_MIN  = 7'b0010000,
		MODE_MON  = 7'b0100000,
		MODE_DOM  = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} time_t;

	typedef struct packed {
		logic [15:0] tps;
		logic [9:0]  lpt;
		logic [4:0]  feb;
	} cfg_t;

	function automatic logic [2:0] mode_code(mode_t m);
		logic [2:0] c;
		case (m)
			MODE_HHMM: c = DMODE_HHMM;
			MODE_SS:   c = DMODE_SS;
			MODE_HH:   c = DMODE_HH;
			MODE_MIN:  c = DMODE_MIN;
			MODE_MON:  c = DMODE_MON;
			MODE_DOM:  c = DMODE_DOM;
			default:   c = DMODE_OFF;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] seg_digit(logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'he0;
			4'd1: s = 8'hf9;
			4'd2: s = 8'hd4;
			4'd3: s = 8'hd8;
			4'd4: s = 8'hc9;
			4'd5: s = 8'hca;
			4'd6: s = 8'hc2;
			4'd7: s = 8'hf8;
			4'd8: s = 8'hc0;
			4'd9: s = 8'hc8;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

@@ design/kscd_core.sv @@
// ----------------------------------------------------------------------------
// kscd_core - key, mode and calendar state
// Holds mode, hold counter, divider, digit mux and clock; computes next state.
// ----------------------------------------------------------------------------
module kscd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       keys,
	input  kscd_pkg::cfg_t   cfg,
	output kscd_pkg::mode_t  mode_n,
	output kscd_pkg::time_t  tm_n,
	output logic [2:0]       mux_n
);

	kscd_pkg::mode_t mode_q;
	kscd_pkg::time_t tm_q;
	kscd_pkg::time_t tm_k;
	logic [2:0]  mux_q;
	logic [2:0]  mux_rot;
	logic [2:0]  last_keys_q;
	logic [9:0]  hold_q;
	logic [9:0]  hold_n;
	logic [9:0]  hold_inc;
	logic [15:0] div_q;
	logic [15:0] div_n;
	logic [15:0] div_inc;
	logic        counting;
	logic        press_short;
	logic        press_long;
	logic        sec_tick;
	logic [6:0]  sec_inc;
	logic [6:0]  min_inc;
	logic [5:0]  hour_inc;
	logic [6:0]  ksec_inc;
	logic [6:0]  kmin_inc;
	logic [5:0]  khour_inc;

	function automatic logic [4:0] days_in(logic [3:0] m, logic [4:0] feb);
		logic [4:0] d;
		case (m)
			4'd2: d = feb;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// day+1 in five bits, back to 1 past the month length
	function automatic logic [4:0] bump_day(logic [4:0] d, logic [3:0] m, logic [4:0] feb);
		logic [4:0] n;
		n = d + 5'd1;
		return (n > days_in(m, feb)) ? 5'd1 : n;
	endfunction

	function automatic logic [3:0] next_month(logic [3:0] m);
		logic [4:0] n;
		n = {1'b0, m} + 5'd1;
		return (n >= 5'd13) ? 4'd1 : n[3:0];
	endfunction

	// digit mux follows the mode held before this tick
	assign mux_rot = {mux_q[1:0], 1'b0};
	assign mux_n   = (mode_q == kscd_pkg::MODE_OFF) ? 3'b000 :
	                 ((mux_rot == 3'b000) ? 3'b001 : mux_rot);

	assign hold_inc    = hold_q + 10'd1;
	assign counting    = (keys != kscd_pkg::KEY_NONE) && (keys == last_keys_q) &&
	                     (hold_q < cfg.lpt);
	assign press_short = counting && (hold_inc == 10'd1);
	assign press_long  = counting && !press_short && (hold_inc == cfg.lpt);
	assign hold_n      = counting ? hold_inc : ((keys == kscd_pkg::KEY_NONE ||
	                     keys != last_keys_q) ? 10'd0 : hold_q);

	assign ksec_inc  = {1'b0, tm_q.second} + 7'd1;
	assign kmin_inc  = {1'b0, tm_q.minute} + 7'd1;
	assign khour_inc = {1'b0, tm_q.hour} + 6'd1;

	// key stage: mode moves and field setting
	always_comb begin
		mode_n = mode_q;
		tm_k   = tm_q;
		if (keys == kscd_pkg::KEY_NONE && mode_q == kscd_pkg::MODE_HHMM) begin
			mode_n = kscd_pkg::MODE_OFF;
		end else if (press_short) begin
			case (mode_q)
				kscd_pkg::MODE_OFF: begin
					if (keys == kscd_pkg::KEY_READ) begin
						mode_n = kscd_pkg::MODE_HHMM;
					end else if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_HH;
					end
				end
				kscd_pkg::MODE_SS: begin
					if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_HH;
					end else if (keys == kscd_pkg::KEY_RC) begin
						tm_k.second = (ksec_inc >= 7'd60) ? 6'd0 : ksec_inc[5:0];
					end
				end
				kscd_pkg::MODE_HH: begin
					if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_MIN;
					end else if (keys == kscd_pkg::KEY_RC) begin
						tm_k.hour = (khour_inc >= 6'd24) ? 5'd0 : khour_inc[4:0];
					end
				end
				kscd_pkg::MODE_MIN: begin
					if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_MON;
					end else if (keys == kscd_pkg::KEY_RC) begin
						tm_k.minute = (kmin_inc >= 7'd60) ? 6'd0 : kmin_inc[5:0];
						tm_k.second = 6'd0;
					end
				end
				kscd_pkg::MODE_MON: begin
					if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_DOM;
					end else if (keys == kscd_pkg::KEY_RC) begin
						tm_k.month = next_month(tm_q.month);
					end
				end
				kscd_pkg::MODE_DOM: begin
					if (keys == kscd_pkg::KEY_SET) begin
						mode_n = kscd_pkg::MODE_OFF;
					end else if (keys == kscd_pkg::KEY_RC) begin
						tm_k.day = bump_day(tm_q.day, tm_q.month, cfg.feb);
					end
				end
				default: begin
				end
			endcase
		end else if (press_long) begin
			if (mode_q == kscd_pkg::MODE_HHMM) begin
				if (keys == kscd_pkg::KEY_READ) begin
					mode_n = kscd_pkg::MODE_SS;
				end
			end else if (mode_q != kscd_pkg::MODE_OFF) begin
				if (keys == kscd_pkg::KEY_SET) begin
					mode_n = kscd_pkg::MODE_OFF;
				end
			end
		end
	end

	// second divider and calendar carries, on top of the key stage
	assign div_inc  = div_q + 16'd1;
	assign sec_tick = (div_inc >= cfg.tps);
	assign div_n    = sec_tick ? 16'd0 : div_inc;
	assign sec_inc  = {1'b0, tm_k.second} + 7'd1;
	assign min_inc  = {1'b0, tm_k.minute} + 7'd1;
	assign hour_inc = {1'b0, tm_k.hour} + 6'd1;

	always_comb begin
		tm_n = tm_k;
		if (sec_tick) begin
			if (sec_inc < 7'd60) begin
				tm_n.second = sec_inc[5:0];
			end else begin
				tm_n.second = 6'd0;
				if (min_inc < 7'd60) begin
					tm_n.minute = min_inc[5:0];
				end else begin
					tm_n.minute = 6'd0;
					if (hour_inc < 6'd24) begin
						tm_n.hour = hour_inc[4:0];
					end else begin
						tm_n.hour = 5'd0;
						tm_n.day  = bump_day(tm_k.day, tm_k.month, cfg.feb);
						if (tm_n.day == 5'd1) begin
							tm_n.month = next_month(tm_k.month);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= kscd_pkg::MODE_OFF;
			mux_q       <= 3'b000;
			last_keys_q <= kscd_pkg::KEY_NONE;
			hold_q      <= 10'd0;
			div_q       <= 16'd0;
			tm_q        <= '{month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};
		end else if (accept) begin
			mode_q      <= mode_n;
			mux_q       <= mux_n;
			last_keys_q <= keys;
			hold_q      <= hold_n;
			div_q       <= div_n;
			tm_q        <= tm_n;
		end
	end

endmodule

@@ design/kscd_disp.sv @@
// ----------------------------------------------------------------------------
// kscd_disp - seven-segment code generation
// Builds the three digit codes and tens flag from mode and time; picks one.
// ----------------------------------------------------------------------------
module kscd_disp (
	input  kscd_pkg::mode_t mode,
	input  kscd_pkg::time_t tm,
	input  logic [2:0]      mux,
	output logic [7:0]      seg,
	output logic            tens
);

	logic [4:0] hr12;
	logic [7:0] hr_code;
	logic       hr_tens;
	logic [7:0] mon_code;
	logic       mon_tens;
	logic [7:0] sec_lo, sec_hi, min_lo, min_hi, day_lo, day_hi;
	logic [7:0] d0, d1, d2;
	logic       tens_f;

	function automatic logic [2:0] dec_hi(logic [5:0] v);
		logic [2:0] q;
		if (v >= 6'd60) q = 3'd6;
		else if (v >= 6'd50) q = 3'd5;
		else if (v >= 6'd40) q = 3'd4;
		else if (v >= 6'd30) q = 3'd3;
		else if (v >= 6'd20) q = 3'd2;
		else if (v >= 6'd10) q = 3'd1;
		else q = 3'd0;
		return q;
	endfunction

	function automatic logic [3:0] dec_lo(logic [5:0] v);
		logic [5:0] q;
		logic [5:0] r;
		q = {3'b000, dec_hi(v)};
		r = v - (q << 3) - (q << 1);
		return r[3:0];
	endfunction

	// left digit: values of ten and up light the leading one
	function automatic logic [8:0] left_digit(logic [4:0] v);
		logic [4:0] d;
		logic       t;
		t = (v >= 5'd10);
		d = t ? (v - 5'd10) : v;
		return {t, kscd_pkg::seg_digit(d[3:0])};
	endfunction

	assign hr12 = (tm.hour == 5'd0) ? 5'd12 : ((tm.hour > 5'd12) ? tm.hour - 5'd12 : tm.hour);
	assign {hr_tens, hr_code}   = left_digit(hr12);
	assign {mon_tens, mon_code} = left_digit({1'b0, tm.month});

	assign sec_lo = kscd_pkg::seg_digit(dec_lo(tm.second));
	assign sec_hi = kscd_pkg::seg_digit({1'b0, dec_hi(tm.second)});
	assign min_lo = kscd_pkg::seg_digit(dec_lo(tm.minute));
	assign min_hi = kscd_pkg::seg_digit({1'b0, dec_hi(tm.minute)});
	assign day_lo = kscd_pkg::seg_digit(dec_lo({1'b0, tm.day}));
	assign day_hi = kscd_pkg::seg_digit({1'b0, dec_hi({1'b0, tm.day})});

	always_comb begin
		d0     = kscd_pkg::SEG_BLANK;
		d1     = kscd_pkg::SEG_BLANK;
		d2     = kscd_pkg::SEG_BLANK;
		tens_f = 1'b0;
		case (mode)
			kscd_pkg::MODE_HHMM: begin
				d2 = hr_code; tens_f = hr_tens; d1 = min_hi; d0 = min_lo;
			end
			kscd_pkg::MODE_SS: begin
				d1 = sec_hi; d0 = sec_lo;
			end
			kscd_pkg::MODE_HH: begin
				d2 = hr_code; tens_f = hr_tens;
				d0 = (tm.hour >= 5'd12) ? kscd_pkg::SEG_PM : kscd_pkg::SEG_AM;
			end
			kscd_pkg::MODE_MIN: begin
				d1 = min_hi; d0 = min_lo;
			end
			kscd_pkg::MODE_MON: begin
				d2 = mon_code; tens_f = mon_tens;
			end
			kscd_pkg::MODE_DOM: begin
				d1 = day_hi; d0 = day_lo;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (mux)
			3'b001:  seg = d0;
			3'b010:  seg = d1;
			3'b100:  seg = d2;
			default: seg = kscd_pkg::SEG_BLANK;
		endcase
	end

	assign tens = (mux == 3'b100) && tens_f;

endmodule

@@ design/key_set_clock_display_fsm.sv @@
// ----------------------------------------------------------------------------
// key_set_clock_display_fsm - key-operated clock display controller
// One input transaction is one multiplex tick with the key lines; one result
// transaction carries the digit drive, mode and current calendar time.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                           | Payload
//  ---------+-----------------------------------+---------------------------------
//  s_axis   | tvalid, tready, tdata[7:0]        | keys[2:0], zero fill
//  m_axis   | tvalid, tready, tdata[47:0]       | digit_select..month_now, zero fill
//  cfg      | valid, ready, index[1:0], data    | 0 ticks_per_second, 1 long_press_ticks,
//           |                                   | 2 february_days
//
//  One tick per cycle: key handling, mode moves, divider and calendar carries
//  and segment coding settle in one pass of logic into the result register.
//  Input is taken whenever the result register is empty or being drained.
//  A stall on m_axis holds the result and, after it, stops s_axis.
//  arst_n clears all state: display off, 00:00:00 on January 1, configuration
//  back to 512 ticks per second, 512 hold ticks and 29 days in February.
//  cfg_ready is always high; writes to an index past the list are dropped.
//
module key_set_clock_display_fsm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [2:0] keys, [7:3] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [2:0] digit_select, [10:3] segments,
	                                    // [11] tens_segment, [14:12] display_mode,
	                                    // [20:15] second_now, [26:21] minute_now,
	                                    // [31:27] hour_now, [36:32] day_now,
	                                    // [40:37] month_now, [47:41] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	kscd_pkg::cfg_t  cfg_q;
	kscd_pkg::mode_t mode_n;
	kscd_pkg::time_t tm_n;
	logic [2:0]      mux_n;
	logic [7:0]      seg;
	logic            tens;
	logic            accept;
	logic            out_valid_q;
	logic [47:0]     out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{tps: kscd_pkg::TPS_RESET, lpt: kscd_pkg::LPT_RESET,
			           feb: kscd_pkg::FEB_RESET};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kscd_pkg::CFG_TPS: cfg_q.tps <= cfg_data;
				kscd_pkg::CFG_LPT: cfg_q.lpt <= cfg_data[9:0];
				kscd_pkg::CFG_FEB: cfg_q.feb <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// state and next-state logic for keys, mode and time
	kscd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.keys   (s_axis_tdata[2:0]),
		.cfg    (cfg_q),
		.mode_n (mode_n),
		.tm_n   (tm_n),
		.mux_n  (mux_n)
	);

	// segment codes follow the mode and time after this tick
	kscd_disp u_disp (
		.mode (mode_n),
		.tm   (tm_n),
		.mux  (mux_n),
		.seg  (seg),
		.tens (tens)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {7'd0, tm_n.month, tm_n.day, tm_n.hour, tm_n.minute, tm_n.second,
			               kscd_pkg::mode_code(mode_n), tens, seg, mux_n};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ design/kscd_chk.sv @@
// ----------------------------------------------------------------------------
// kscd_chk - port-level checks
// Watches the streaming ports of the clock display controller.
// ----------------------------------------------------------------------------
module kscd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// an empty result register never blocks input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// every accepted tick yields a result next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick gave no result");

	// digit drive is one-hot or dark
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
		else $error("digit select not one-hot");

	// leading one only with the third digit
	a_tens: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[2])
		else $error("tens segment without third digit");

endmodule

bind key_set_clock_display_fsm kscd_chk u_kscd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
